>>> rtl/core/record_sort_by_selected_key_core_assert.svh
// assertion macros for the record sorter core
// plain text macros, no package or module dependencies
`ifndef RECORD_SORT_BY_SELECTED_KEY_CORE_ASSERT_SVH
`define RECORD_SORT_BY_SELECTED_KEY_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define RSK_ASSERT_IMPLY(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define RSK_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rsk_pkg.sv
// shared types, constants and key select for the record sorter core
// no dependencies
package rsk_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 64;

  localparam int unsigned ID_W    = 27;
  localparam int unsigned SCORE_W = 14;
  localparam int unsigned TOTAL_W = 15;
  localparam int unsigned KEY_W   = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(10000);

  // sort key codes
  localparam logic [KEY_W-1:0] KEY_FIRST  = 2'd0;
  localparam logic [KEY_W-1:0] KEY_SECOND = 2'd1;
  localparam logic [KEY_W-1:0] KEY_THIRD  = 2'd2;
  localparam logic [KEY_W-1:0] KEY_TOTAL  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    record_id;
    logic [SCORE_W-1:0] score_first;
    logic [SCORE_W-1:0] score_second;
    logic [SCORE_W-1:0] score_third;
    logic               load_last;
  } load_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_id;
    logic [SCORE_W-1:0] out_first;
    logic [SCORE_W-1:0] out_second;
    logic [SCORE_W-1:0] out_third;
    logic [TOTAL_W-1:0] out_total;
    logic               out_last;
    logic               dropped;
  } result_t;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] first;
    logic [SCORE_W-1:0] second;
    logic [SCORE_W-1:0] third;
    logic [TOTAL_W-1:0] total;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] v);
    clamp_score = (v > SCORE_MAX) ? SCORE_MAX : v;
  endfunction

  function automatic logic [TOTAL_W-1:0] key_of(input rec_t r, input logic [KEY_W-1:0] sel);
    case (sel)
      KEY_FIRST:  key_of = TOTAL_W'(r.first);
      KEY_SECOND: key_of = TOTAL_W'(r.second);
      KEY_THIRD:  key_of = TOTAL_W'(r.third);
      KEY_TOTAL:  key_of = r.total;
      default:    key_of = r.total;
    endcase
  endfunction

endpackage

>>> rtl/core/record_sort_by_selected_key_core.sv
// record sorter core: load store, selection sequencer and result strobe
// depends on rsk_pkg and record_sort_by_selected_key_core_assert.svh
`include "record_sort_by_selected_key_core_assert.svh"

// Records are loaded one per cycle with start while busy is low; each score is
// clamped to 0..10000 and the total of the three is stored with the record.
// A load that finds the store full (MAX_RECORDS held) is discarded and the run
// is flagged as dropped. A load marked last (stored or not) starts the sort and
// raises busy. The sorter emits every held record in descending order of the
// key picked by sort_key, ties in load order. Each output is found by one
// shared key comparator that walks the record memory one entry per cycle (one
// read port, registered data), then the winner is read back and shown for one
// cycle with result_valid. Once every held record is out, busy drops and a new
// set begins. The receiver cannot stall: each result is a single-cycle
// transfer. sort_key is written over the cfg channel (always ready) and should
// only change while busy is low.
module record_sort_by_selected_key_core #(
  parameter int unsigned MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // load channel
  input  logic                       start,
  output logic                       busy,
  input  rsk_pkg::load_item_t        load_item,
  // result strobe
  output logic                       result_valid,
  output rsk_pkg::result_t           result,
  // sort key register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rsk_pkg::KEY_W-1:0]  cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

  // record memory, one write port (load) and one registered read port
  rsk_pkg::rec_t mem [MAX_RECORDS];
  rsk_pkg::rec_t rd_data;
  logic [IDX_W-1:0] rd_addr;

  rsk_pkg::state_t state, state_next;

  logic [rsk_pkg::KEY_W-1:0]   sort_key;
  logic [CNT_W-1:0]            held_count;
  logic                        overflow_seen;
  logic [MAX_RECORDS-1:0]      emitted;     // records already sent in this run
  logic [IDX_W-1:0]            scan_idx;
  logic [CNT_W-1:0]            out_cnt;
  logic                        pipe_valid;  // rd_data holds a candidate
  logic [IDX_W-1:0]            pipe_idx;
  logic                        best_found;
  logic [IDX_W-1:0]            best_idx;
  logic [rsk_pkg::TOTAL_W-1:0] best_key;
  logic [rsk_pkg::TOTAL_W-1:0] cand_key;

  logic          load_xfer;
  logic          store_ok;
  logic          scan_end;
  logic          out_end;
  rsk_pkg::rec_t load_rec;

  assign busy      = (state != rsk_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_xfer = start && !busy;
  assign store_ok  = (held_count < CNT_W'(MAX_RECORDS));
  assign scan_end  = (CNT_W'(scan_idx) == held_count - CNT_W'(1));
  assign out_end   = (out_cnt == held_count - CNT_W'(1));

  // clamp and total on the way in
  always_comb begin
    load_rec.id     = load_item.record_id;
    load_rec.first  = rsk_pkg::clamp_score(load_item.score_first);
    load_rec.second = rsk_pkg::clamp_score(load_item.score_second);
    load_rec.third  = rsk_pkg::clamp_score(load_item.score_third);
    load_rec.total  = rsk_pkg::TOTAL_W'(load_rec.first) + rsk_pkg::TOTAL_W'(load_rec.second)
                    + rsk_pkg::TOTAL_W'(load_rec.third);
  end

  // read address: scan pointer, or the winner when fetching it for output
  assign rd_addr = (state == rsk_pkg::ST_FETCH) ? best_idx : scan_idx;

  always_ff @(posedge clk) begin
    if (load_xfer && store_ok) begin
      mem[held_count[IDX_W-1:0]] <= load_rec;
    end
    rd_data <= mem[rd_addr];
  end

  // shared comparator input
  assign cand_key = rsk_pkg::key_of(rd_data, sort_key);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rsk_pkg::ST_IDLE: begin
        if (load_xfer && load_item.load_last) begin
          state_next = rsk_pkg::ST_SCAN;
        end
      end
      rsk_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = rsk_pkg::ST_DRAIN;
        end
      end
      rsk_pkg::ST_DRAIN: state_next = rsk_pkg::ST_FETCH;
      rsk_pkg::ST_FETCH: state_next = rsk_pkg::ST_EMIT;
      rsk_pkg::ST_EMIT: begin
        state_next = out_end ? rsk_pkg::ST_IDLE : rsk_pkg::ST_SCAN;
      end
      default: state_next = rsk_pkg::ST_IDLE;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key      <= rsk_pkg::KEY_TOTAL;
      held_count    <= '0;
      overflow_seen <= 1'b0;
      emitted       <= '0;
      scan_idx      <= '0;
      out_cnt       <= '0;
      pipe_valid    <= 1'b0;
      best_found    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sort_key <= cfg_data;
      end

      // candidate stage is registered alongside the memory read data
      pipe_valid <= (state == rsk_pkg::ST_SCAN) && !emitted[scan_idx];
      pipe_idx   <= scan_idx;

      // strict compare keeps the earliest record on equal keys
      if (pipe_valid && (!best_found || cand_key > best_key)) begin
        best_found <= 1'b1;
        best_key   <= cand_key;
        best_idx   <= pipe_idx;
      end

      case (state)
        rsk_pkg::ST_IDLE: begin
          if (load_xfer) begin
            if (store_ok) begin
              held_count <= held_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (load_item.load_last) begin
              emitted    <= '0;
              scan_idx   <= '0;
              out_cnt    <= '0;
              best_found <= 1'b0;
            end
          end
        end
        rsk_pkg::ST_SCAN: begin
          if (!scan_end) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        rsk_pkg::ST_EMIT: begin
          emitted[best_idx] <= 1'b1;
          out_cnt           <= out_cnt + CNT_W'(1);
          scan_idx          <= '0;
          best_found        <= 1'b0;
          if (out_end) begin
            held_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result transfer straight from the registered winner read
  assign result_valid = (state == rsk_pkg::ST_EMIT);

  always_comb begin
    result.out_id     = rd_data.id;
    result.out_first  = rd_data.first;
    result.out_second = rd_data.second;
    result.out_third  = rd_data.third;
    result.out_total  = rd_data.total;
    result.out_last   = out_end;
    result.dropped    = overflow_seen;
  end

  // a winner must exist whenever a result goes out
  `RSK_ASSERT_IMPLY(a_emit_has_winner, clk, rst, result_valid, best_found, "emit without winner")
  // the store count never passes capacity
  `RSK_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, held_count <= CNT_W'(MAX_RECORDS),
    "held count above capacity")
  // a last load starts a run
  `RSK_ASSERT_NEXT(a_last_starts_run, clk, rst, load_xfer && load_item.load_last, busy,
    "last load did not start the run")
  // the final result ends the run and empties the store
  `RSK_ASSERT_NEXT(a_last_ends_run, clk, rst, result_valid && result.out_last,
    !busy && held_count == '0, "run did not end after final result")

endmodule
